/* src/rssa_pkg.sv */
// shared types, constants and functions of the random-state seed and advance unit
package rssa_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] ZERO_REPLACE = 64'd88172645463325252;
    localparam logic [63:0] LCG_MUL      = 64'd1103515245;
    localparam logic [63:0] LCG_ADD      = 64'd12345;
    localparam logic [63:0] MUL_ONE      = 64'd1;

    // configuration register indexes
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // generator modes
    localparam logic MODE_XS  = 1'b0;
    localparam logic MODE_LCG = 1'b1;

    // input operations
    localparam logic OP_SEED    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // cycles from input transfer to result strobe
    localparam int LATENCY = 9;

    typedef struct packed {
        logic vld;
        logic seed;
        logic lcg;
    } t_tag;

    function automatic logic [63:0] f_xs64(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    // five lcg steps, only evaluated on constants
    function automatic logic [63:0] f_lcg5(input logic [63:0] v);
        logic [63:0] s;
        s = v;
        for (int k = 0; k < 5; k++) begin
            s = s * LCG_MUL + LCG_ADD;
        end
        return s;
    endfunction

    // five steps folded into one affine map s * LCG5_MUL + LCG5_ADD
    localparam logic [63:0] LCG5_ADD = f_lcg5(64'd0);
    localparam logic [63:0] LCG5_MUL = f_lcg5(64'd1) - LCG5_ADD;

endpackage

/* src/rssa_mul64.sv */
// two-stage 64 by 64 bit multiplier, low 64 bits of the product
module rssa_mul64 import rssa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tag        i_tag,
    input  logic [63:0] i_a,
    input  logic [63:0] i_k,
    output t_tag        o_tag,
    output logic [63:0] o_p
);

    logic [31:0] a_lo;
    logic [31:0] a_hi;
    logic [31:0] k_lo;
    logic [31:0] k_hi;
    logic [63:0] n_p0;
    logic [31:0] n_px;
    logic [31:0] n_py;
    logic [63:0] n_p;

    t_tag        r_tag1;
    logic [63:0] r_p0;
    logic [31:0] r_px;
    logic [31:0] r_ahi;
    logic [31:0] r_klo;
    t_tag        r_tag2;
    logic [63:0] r_p;

    assign a_lo = i_a[31:0];
    assign a_hi = i_a[63:32];
    assign k_lo = i_k[31:0];
    assign k_hi = i_k[63:32];

    // low by low full product, one cross term low half
    assign n_p0 = {32'd0, a_lo} * {32'd0, k_lo};
    assign n_px = a_lo * k_hi;

    // second cross term and final sum
    assign n_py = r_ahi * r_klo;
    assign n_p  = r_p0 + {r_px + n_py, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= n_p0;
        r_px  <= n_px;
        r_ahi <= a_hi;
        r_klo <= k_lo;
        r_p   <= n_p;
    end

    assign o_tag = r_tag2;
    assign o_p   = r_p;

endmodule

/* src/rssa_front.sv */
// first three stages: index or state pick with xorshift, seed add and pre-mix; in lcg mode index scaling and seed add
module rssa_front import rssa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_operation,
    input  logic [63:0] i_element_index,
    input  logic [63:0] i_state_in,
    input  logic        i_mode,
    input  logic [63:0] i_seed,
    input  logic [63:0] i_seed_g,
    output t_tag        o_tag,
    output logic [63:0] o_val
);

    t_tag        n_tag1;
    logic [63:0] base;
    logic [63:0] n_val1;
    logic [63:0] n_val2;
    logic [63:0] n_val3;

    t_tag        r_tag1;
    logic [63:0] r_val1;
    t_tag        r_tag2;
    logic [63:0] r_val2;
    t_tag        r_tag3;
    logic [63:0] r_val3;

    assign n_tag1.vld  = i_take;
    assign n_tag1.seed = (i_operation == OP_SEED);
    assign n_tag1.lcg  = (i_mode == MODE_LCG);

    assign base   = (i_operation == OP_SEED) ? i_element_index + 64'd1 : i_state_in;
    assign n_val1 = (i_mode == MODE_LCG) ? base : f_xs64(base);

    always_comb begin
        n_val2 = r_val1;
        if (r_tag1.seed && !r_tag1.lcg) begin
            n_val2 = r_val1 + i_seed_g;
        end else if (r_tag1.seed && r_tag1.lcg) begin
            // index plus one times 2^31 - 1
            n_val2 = (r_val1 << 31) - r_val1;
        end
    end

    always_comb begin
        n_val3 = r_val2;
        if (r_tag2.seed && !r_tag2.lcg) begin
            n_val3 = r_val2 ^ (r_val2 >> 30);
        end else if (r_tag2.seed && r_tag2.lcg) begin
            n_val3 = r_val2 + i_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= n_tag1;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val1 <= n_val1;
        r_val2 <= n_val2;
        r_val3 <= n_val3;
    end

    assign o_tag = r_tag3;
    assign o_val = r_val3;

endmodule

/* src/random_state_seed_and_advance.sv */
// top level of the random-state seed and advance unit
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | i_start, o_busy        | i_operation, i_element_index, i_state_in
//  result   | o_valid                | o_state_out
//  config   | i_cfg_we               | i_cfg_addr, i_cfg_wdata
//
//  one item per cycle while o_busy is low; the result strobe follows the transfer
//  through the front stages, two two-stage multipliers and two mix stages
//  o_busy is high during reset and in the first cycle after it, then stays low
//  reset clears all valid bits and the seed and mode registers, and sets the derived seed register to the golden gamma
//  the receiver cannot stall, so the pipeline advances on every clock
module random_state_seed_and_advance import rssa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [63:0] i_element_index,
    input  logic [63:0] i_state_in,
    output logic        o_valid,
    output logic [63:0] o_state_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_wdata
);

    logic        r_run;
    logic [63:0] r_seed;
    logic [63:0] r_seed_g;
    logic        r_mode;

    logic        take;
    t_tag        f_tag;
    logic [63:0] f_val;
    logic [63:0] k1;
    t_tag        m1_tag;
    logic [63:0] m1_p;
    logic [63:0] n_val6;
    t_tag        r_tag6;
    logic [63:0] r_val6;
    logic [63:0] k2;
    t_tag        m2_tag;
    logic [63:0] m2_p;
    logic [63:0] mixed;
    logic [63:0] n_val9;
    t_tag        r_tag9;
    logic [63:0] r_val9;

    assign o_busy = !r_run;
    assign take   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_seed   <= '0;
            r_seed_g <= GOLDEN_GAMMA;
            r_mode   <= MODE_XS;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we && i_cfg_addr == CFG_SEED) begin
                r_seed   <= i_cfg_wdata;
                r_seed_g <= i_cfg_wdata + GOLDEN_GAMMA;
            end
            if (i_cfg_we && i_cfg_addr == CFG_MODE) begin
                r_mode <= i_cfg_wdata[0];
            end
        end
    end

    rssa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_state_in      (i_state_in),
        .i_mode          (r_mode),
        .i_seed          (r_seed),
        .i_seed_g        (r_seed_g),
        .o_tag           (f_tag),
        .o_val           (f_val)
    );

    // multiply by one lets an item pass unchanged
    always_comb begin
        k1 = MUL_ONE;
        if (f_tag.lcg) begin
            k1 = LCG5_MUL;
        end else if (f_tag.seed) begin
            k1 = MIX_MUL_A;
        end
    end

    rssa_mul64 u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (f_tag),
        .i_a     (f_val),
        .i_k     (k1),
        .o_tag   (m1_tag),
        .o_p     (m1_p)
    );

    always_comb begin
        n_val6 = m1_p;
        if (m1_tag.lcg) begin
            n_val6 = m1_p + LCG5_ADD;
        end else if (m1_tag.seed) begin
            n_val6 = m1_p ^ (m1_p >> 27);
        end
    end

    assign k2 = (r_tag6.seed && !r_tag6.lcg) ? MIX_MUL_B : MUL_ONE;

    rssa_mul64 u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag6),
        .i_a     (r_val6),
        .i_k     (k2),
        .o_tag   (m2_tag),
        .o_p     (m2_p)
    );

    // final mix with zero replacement
    assign mixed = m2_p ^ (m2_p >> 31);

    always_comb begin
        n_val9 = m2_p;
        if (m2_tag.seed && !m2_tag.lcg) begin
            n_val9 = (mixed == 64'd0) ? ZERO_REPLACE : mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag6 <= '0;
            r_tag9 <= '0;
        end else begin
            r_tag6 <= m1_tag;
            r_tag9 <= m2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val6 <= n_val6;
        r_val9 <= n_val9;
    end

    assign o_valid     = r_tag9.vld;
    assign o_state_out = r_val9;

`ifndef SYNTHESIS
    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LATENCY o_valid)
        else $error("result strobe missing after transfer");

    a_no_result_without_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, LATENCY))
        else $error("result strobe without earlier transfer");

    a_seed_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag9.vld && r_tag9.seed && !r_tag9.lcg) |-> (o_state_out != 64'd0))
        else $error("zero state from xorshift seeding");
`endif

endmodule

/* verif/random_state_seed_and_advance_checker.sv */
// checker of the random-state unit: predicts each state from the input transfers and compares results
module random_state_seed_and_advance_checker import rssa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_operation,
    input  logic [63:0] i_element_index,
    input  logic [63:0] i_state_in,
    input  logic        i_valid,
    input  logic [63:0] i_state_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_outstanding
);

    localparam logic [63:0] K_GAMMA     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] K_MIX1      = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] K_MIX2      = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] K_ZERO_FILL = 64'd88172645463325252;
    localparam logic [63:0] K_LCG_MUL   = 64'd1103515245;
    localparam logic [63:0] K_LCG_INC   = 64'd12345;
    localparam logic [63:0] K_INDEX_MUL = 64'd2147483647;

    logic [63:0] seed_reg = '0;
    logic        mode_reg = MODE_XS;
    logic [63:0] expected_states[$];
    int          fail_count = 0;

    assign o_errors = fail_count;

    function automatic logic [63:0] xorshift_step(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function automatic logic [63:0] lcg_five(input logic [63:0] v);
        logic [63:0] s;
        s = v;
        repeat (5) s = s * K_LCG_MUL + K_LCG_INC;
        return s;
    endfunction

    function automatic logic [63:0] splitmix_finish(input logic [63:0] v);
        logic [63:0] z;
        z = v + K_GAMMA;
        z = (z ^ (z >> 30)) * K_MIX1;
        z = (z ^ (z >> 27)) * K_MIX2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] predict_state(input logic op, input logic [63:0] index,
                                                  input logic [63:0] state,
                                                  input logic [63:0] seed, input logic mode);
        logic [63:0] r;
        if (op == OP_SEED) begin
            if (mode == MODE_XS) begin
                r = splitmix_finish(xorshift_step(index + 64'd1) + seed);
                // an all-zero seeded state is never handed out
                if (r == 64'd0) r = K_ZERO_FILL;
            end else begin
                r = lcg_five((index + 64'd1) * K_INDEX_MUL + seed);
            end
        end else if (mode == MODE_XS) begin
            r = xorshift_step(state);
        end else begin
            r = lcg_five(state);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [63:0] want;
        if (!i_rst_n) begin
            seed_reg = '0;
            mode_reg = MODE_XS;
            expected_states.delete();
            o_outstanding <= 0;
        end else begin
            if (i_valid) begin
                if (expected_states.size() == 0) begin
                    $error("state_out: expected nothing, actual %h", i_state_out);
                    fail_count++;
                end else begin
                    want = expected_states.pop_front();
                    if (i_state_out !== want) begin
                        $error("state_out: expected %h, actual %h", want, i_state_out);
                        fail_count++;
                    end
                end
            end
            // input transfer
            if (i_start && !i_busy) begin
                expected_states.push_back(predict_state(i_operation, i_element_index,
                                                        i_state_in, seed_reg, mode_reg));
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SEED: seed_reg = i_cfg_wdata;
                    CFG_MODE: mode_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            o_outstanding <= expected_states.size();
        end
    end

endmodule

/* verif/random_state_seed_and_advance_test.sv */
// top of the random-state unit test: clock, reset, stimulus, checker hookup and verdict
module random_state_seed_and_advance_test import rssa_pkg::*;;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [63:0] ZERO_SEED   = 64'd0 - GOLDEN_GAMMA;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_operation = OP_SEED;
    logic [63:0] i_element_index = '0;
    logic [63:0] i_state_in = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = CFG_SEED;
    logic [63:0] i_cfg_wdata = '0;
    logic        o_busy;
    logic        o_valid;
    logic [63:0] o_state_out;
    int          err_count;
    int          outstanding;
    int          cycle_count = 0;

    random_state_seed_and_advance dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_state_in      (i_state_in),
        .o_valid         (o_valid),
        .o_state_out     (o_state_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    random_state_seed_and_advance_checker state_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_operation     (i_operation),
        .i_element_index (i_element_index),
        .i_state_in      (i_state_in),
        .i_valid         (o_valid),
        .i_state_out     (o_state_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_errors        (err_count),
        .o_outstanding   (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("random_state_seed_and_advance_test: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // corner values mixed with full-width random words
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 15));
            3: return ~64'($urandom_range(0, 15));
            default: return rand_word();
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [63:0] index, input logic [63:0] state);
        i_start <= 1'b1;
        i_operation <= op;
        i_element_index <= index;
        i_state_in <= state;
        do @(negedge i_clk); while (o_busy);
        @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending until every expected state is back
    task automatic drain();
        i_start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] seed, input logic mode);
        logic [63:0] noise;
        noise = rand_word();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_SEED;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MODE;
        i_cfg_wdata <= {noise[63:1], mode};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit with_gaps);
        int n;
        for (n = 0; n < count; n++) begin
            if (with_gaps && $urandom_range(0, 15) == 0) hold_off($urandom_range(1, 13));
            send_item(logic'($urandom_range(0, 1)), pick_word(), pick_word());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: zero seed, xorshift mode
        send_item(OP_SEED, 64'd0, rand_word());
        send_item(OP_SEED, '1, rand_word());
        send_item(OP_ADVANCE, rand_word(), 64'd0);
        send_item(OP_ADVANCE, rand_word(), '1);
        hold_off(3);
        send_item(OP_ADVANCE, rand_word(), 64'd1);
        drain();

        // finalizer input of zero for index all ones
        set_config(ZERO_SEED, MODE_XS);
        send_item(OP_SEED, '1, rand_word());
        send_item(OP_SEED, 64'd0, rand_word());
        send_item(OP_ADVANCE, rand_word(), 64'd0);
        drain();

        set_config('1, MODE_LCG);
        send_item(OP_SEED, 64'd0, rand_word());
        send_item(OP_SEED, '1, rand_word());
        send_item(OP_ADVANCE, rand_word(), 64'd0);
        send_item(OP_ADVANCE, rand_word(), '1);
        drain();

        set_config(64'd0, MODE_LCG);
        send_item(OP_SEED, 64'd5, rand_word());
        send_item(OP_ADVANCE, rand_word(), 64'd7);
        drain();

        set_config(rand_word(), MODE_XS);
        run_random(200, 1'b1);
        drain();
        set_config(rand_word(), MODE_LCG);
        run_random(200, 1'b1);
        drain();
        set_config('1, MODE_XS);
        run_random(150, 1'b1);
        drain();
        set_config(64'd0, MODE_LCG);
        run_random(150, 1'b1);
        drain();
        set_config(ZERO_SEED, MODE_XS);
        run_random(100, 1'b1);
        drain();
        set_config(rand_word(), logic'($urandom_range(0, 1)));
        run_random(300, 1'b0);
        drain();

        if (err_count == 0) begin
            $display("random_state_seed_and_advance_test: clean");
        end else begin
            $display("random_state_seed_and_advance_test: errors");
        end
        $finish;
    end

endmodule
